>>> src/wss_pkg.sv
package wss_pkg;

	localparam int CHAN_W = 8;
	localparam int POS_W  = 12;
	localparam int FRAC_W = 8;
	localparam int CELL_W = POS_W - FRAC_W;
	localparam int PIX_W  = 3 * CHAN_W;
	// wide enough for any grid index or row * cols + col
	localparam int IDX_W  = 17;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// item kinds carried on s_tuser
	localparam logic KIND_SPLAT = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	typedef enum logic [8:0] {
		ST_CLEAR  = 9'b000000001,
		ST_IDLE   = 9'b000000010,
		ST_WEIGHT = 9'b000000100,
		ST_ADDR   = 9'b000001000,
		ST_LOAD   = 9'b000010000,
		ST_SCALE  = 9'b000100000,
		ST_WRITE  = 9'b001000000,
		ST_RDADDR = 9'b010000000,
		ST_RDDATA = 9'b100000000
	} state_t;

	// one operation of the shared multiply / saturating-add unit
	typedef struct packed {
		logic [CHAN_W-1:0] a;
		logic [CHAN_W-1:0] b;
		logic [CHAN_W-1:0] acc;
		logic              weight;
	} mac_op_t;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} pixel_t;

endpackage

>>> src/wu_subpixel_splat.sv
// Read item: the store is read from RDADDR and the result posts from RDDATA once the slot
// is free. Splat item: four corner weights in WEIGHT, then ADDR, LOAD, SCALE per channel
// and WRITE per neighbor on the grid (only ADDR per dropped neighbor), the result posting
// with the last of them. All work runs through one 8x8 multiply / saturating-add unit; a
// waiting result holds the end. Reset is asynchronous: control clears at once, then a
// clearing pass zeroes all GRID_COLS*GRID_ROWS words of the frame store with s_tready low.
module wu_subpixel_splat #(
	parameter int GRID_COLS = 16,
	parameter int GRID_ROWS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pos_x[11:0], pos_y[23:12], red[31:24], green[39:32], blue[47:40], pixel_index[55:48]
	input  logic [55:0] s_tdata,
	// kind[0]
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pixel_red[7:0], pixel_green[15:8], pixel_blue[23:16]
	output logic [23:0] m_tdata
);

	localparam int NUM_PIXELS = GRID_COLS * GRID_ROWS;
	localparam int ADDR_W     = $clog2(NUM_PIXELS);
	localparam logic [wss_pkg::IDX_W-1:0] COLS_L = wss_pkg::IDX_W'(GRID_COLS);
	localparam logic [wss_pkg::IDX_W-1:0] ROWS_L = wss_pkg::IDX_W'(GRID_ROWS);
	localparam logic [wss_pkg::IDX_W-1:0] NPIX_L = wss_pkg::IDX_W'(NUM_PIXELS);
	localparam logic [ADDR_W-1:0]         LAST_A = ADDR_W'(NUM_PIXELS - 1);

	wss_pkg::state_t state_q;
	logic [ADDR_W-1:0]          clr_q;
	logic [1:0]                 k_q;
	logic [1:0]                 c_q;
	logic [wss_pkg::POS_W-1:0]  pos_x_q;
	logic [wss_pkg::POS_W-1:0]  pos_y_q;
	logic [wss_pkg::CHAN_W-1:0] colour_q [3];
	logic [wss_pkg::CHAN_W-1:0] w_q [4];
	logic [ADDR_W-1:0]          addr_q;
	logic                       in_range_q;
	wss_pkg::pixel_t            pix_q;
	wss_pkg::pixel_t            res_q;
	logic                       m_tvalid_q;
	logic [23:0]                m_tdata_q;

	wss_pkg::mac_op_t           op;
	logic [wss_pkg::CHAN_W-1:0] mac_res;
	logic [wss_pkg::FRAC_W-1:0] fx;
	logic [wss_pkg::FRAC_W-1:0] fy;
	logic [wss_pkg::CELL_W:0]   nb_col;
	logic [wss_pkg::CELL_W:0]   nb_row;
	logic [wss_pkg::IDX_W-1:0]  nb_lin;
	logic                       nb_on_grid;
	logic [wss_pkg::IDX_W-1:0]  rd_idx;
	logic                       accept;
	logic                       post;
	logic                       done;
	logic                       mem_we;
	logic [ADDR_W-1:0]          mem_waddr;
	logic [ADDR_W-1:0]          mem_raddr;
	wss_pkg::pixel_t            mem_wdata;
	wss_pkg::pixel_t            mem_rdata;
	logic [wss_pkg::CHAN_W-1:0] chan_acc;

	assign s_tready = (state_q == wss_pkg::ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign fx = pos_x_q[wss_pkg::FRAC_W-1:0];
	assign fy = pos_y_q[wss_pkg::FRAC_W-1:0];

	always_comb begin
		nb_col = {1'b0, pos_x_q[wss_pkg::POS_W-1:wss_pkg::FRAC_W]} +
			(wss_pkg::CELL_W+1)'(k_q[0]);
		nb_row = {1'b0, pos_y_q[wss_pkg::POS_W-1:wss_pkg::FRAC_W]} +
			(wss_pkg::CELL_W+1)'(k_q[1]);
		nb_on_grid = (wss_pkg::IDX_W'(nb_col) < COLS_L) && (wss_pkg::IDX_W'(nb_row) < ROWS_L);
		nb_lin = wss_pkg::IDX_W'(nb_row) * COLS_L + wss_pkg::IDX_W'(nb_col);
		rd_idx = wss_pkg::IDX_W'(s_tdata[55:48]);
	end

	// operand select for the shared unit
	always_comb begin
		case (c_q)
			2'd0:    chan_acc = pix_q.red;
			2'd1:    chan_acc = pix_q.green;
			default: chan_acc = pix_q.blue;
		endcase
		if (state_q == wss_pkg::ST_WEIGHT) begin
			op.a      = k_q[0] ? fx : ~fx;
			op.b      = k_q[1] ? fy : ~fy;
			op.acc    = '0;
			op.weight = 1'b1;
		end else begin
			op.a      = colour_q[c_q];
			op.b      = w_q[k_q];
			op.acc    = chan_acc;
			op.weight = 1'b0;
		end
	end

	wss_mac u_mac (
		.op  (op),
		.res (mac_res)
	);

	always_comb begin
		mem_we    = (state_q == wss_pkg::ST_CLEAR) || (state_q == wss_pkg::ST_WRITE);
		mem_waddr = (state_q == wss_pkg::ST_CLEAR) ? clr_q : addr_q;
		mem_wdata = (state_q == wss_pkg::ST_CLEAR) ? '0 : pix_q;
		mem_raddr = (state_q == wss_pkg::ST_ADDR) ? nb_lin[ADDR_W-1:0] : addr_q;
	end

	wss_frame_mem #(
		.DEPTH  (NUM_PIXELS),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result slot frees when empty or being taken this cycle
	assign post = (state_q == wss_pkg::ST_RDDATA || state_q == wss_pkg::ST_WRITE ||
		state_q == wss_pkg::ST_ADDR) && (!m_tvalid_q || m_tready);

	// last step of an item with the slot free: post the result
	assign done = post && ((state_q == wss_pkg::ST_RDDATA) || ((k_q == 2'd3) &&
		((state_q == wss_pkg::ST_WRITE) || (state_q == wss_pkg::ST_ADDR && !nb_on_grid))));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wss_pkg::ST_CLEAR;
			clr_q      <= '0;
			k_q        <= '0;
			c_q        <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				wss_pkg::ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_A) begin
						state_q <= wss_pkg::ST_IDLE;
					end
				end
				wss_pkg::ST_IDLE: begin
					if (accept) begin
						k_q <= '0;
						c_q <= '0;
						state_q <= (s_tuser == wss_pkg::KIND_READ) ?
							wss_pkg::ST_RDADDR : wss_pkg::ST_WEIGHT;
					end
				end
				wss_pkg::ST_WEIGHT: begin
					k_q <= k_q + 1'b1;
					if (k_q == 2'd3) begin
						state_q <= wss_pkg::ST_ADDR;
					end
				end
				wss_pkg::ST_ADDR: begin
					if (nb_on_grid) begin
						state_q <= wss_pkg::ST_LOAD;
					end else if (k_q != 2'd3) begin
						k_q <= k_q + 1'b1;
					end else if (post) begin
						state_q <= wss_pkg::ST_IDLE;
					end
				end
				wss_pkg::ST_LOAD: begin
					c_q     <= '0;
					state_q <= wss_pkg::ST_SCALE;
				end
				wss_pkg::ST_SCALE: begin
					c_q <= c_q + 1'b1;
					if (c_q == 2'd2) begin
						state_q <= wss_pkg::ST_WRITE;
					end
				end
				wss_pkg::ST_WRITE: begin
					// the write repeats harmlessly while the result slot is busy
					if (k_q != 2'd3) begin
						k_q     <= k_q + 1'b1;
						state_q <= wss_pkg::ST_ADDR;
					end else if (post) begin
						state_q <= wss_pkg::ST_IDLE;
					end
				end
				wss_pkg::ST_RDADDR: begin
					state_q <= wss_pkg::ST_RDDATA;
				end
				wss_pkg::ST_RDDATA: begin
					if (post) begin
						state_q <= wss_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= wss_pkg::ST_CLEAR;
					clr_q   <= '0;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_x_q     <= s_tdata[11:0];
			pos_y_q     <= s_tdata[23:12];
			colour_q[0] <= s_tdata[31:24];
			colour_q[1] <= s_tdata[39:32];
			colour_q[2] <= s_tdata[47:40];
			addr_q      <= rd_idx[ADDR_W-1:0];
			in_range_q  <= rd_idx < NPIX_L;
			res_q       <= '0;
		end
		if (state_q == wss_pkg::ST_WEIGHT) begin
			w_q[k_q] <= mac_res;
		end
		if (state_q == wss_pkg::ST_ADDR) begin
			addr_q <= nb_lin[ADDR_W-1:0];
		end
		if (state_q == wss_pkg::ST_LOAD) begin
			pix_q <= mem_rdata;
		end
		if (state_q == wss_pkg::ST_SCALE) begin
			case (c_q)
				2'd0:    pix_q.red   <= mac_res;
				2'd1:    pix_q.green <= mac_res;
				default: pix_q.blue  <= mac_res;
			endcase
		end
		if (state_q == wss_pkg::ST_RDDATA && !post) begin
			res_q <= in_range_q ? mem_rdata : '0;
		end
		if (post) begin
			if (state_q == wss_pkg::ST_RDDATA) begin
				m_tdata_q <= in_range_q ? mem_rdata : '0;
			end else begin
				m_tdata_q <= res_q;
			end
		end
	end

endmodule

>>> src/wss_mac.sv
module wss_mac (
	input  wss_pkg::mac_op_t         op,
	output logic [wss_pkg::CHAN_W-1:0] res
);

	logic [2*wss_pkg::CHAN_W-1:0] full;
	logic [wss_pkg::CHAN_W:0]     sum;

	// weight: (a*b + a + b) >> 8, scale: (a*b) >> 8; both added to acc with saturation
	always_comb begin
		full = (2*wss_pkg::CHAN_W)'(op.a) * (2*wss_pkg::CHAN_W)'(op.b);
		if (op.weight) begin
			full = full + (2*wss_pkg::CHAN_W)'(op.a) + (2*wss_pkg::CHAN_W)'(op.b);
		end
		sum = {1'b0, op.acc} + {1'b0, full[2*wss_pkg::CHAN_W-1:wss_pkg::CHAN_W]};
		res = sum[wss_pkg::CHAN_W] ? wss_pkg::CHAN_MAX : sum[wss_pkg::CHAN_W-1:0];
	end

endmodule

>>> src/wss_frame_mem.sv
module wss_frame_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [ADDR_W-1:0]          waddr,
	input  wss_pkg::pixel_t            wdata,
	input  logic [ADDR_W-1:0]          raddr,
	output wss_pkg::pixel_t            rdata
);

	wss_pkg::pixel_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> tb/tb_wu_subpixel_splat.sv
`timescale 1ns / 100ps

module tb_wu_subpixel_splat;

	localparam int GRID_COLS  = 16;
	localparam int GRID_ROWS  = 16;
	localparam int NUM_PIXELS = GRID_COLS * GRID_ROWS;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	// s_tdata layout, last field in the lowest bits
	typedef struct packed {
		logic [7:0]  pixel_index;
		logic [7:0]  blue;
		logic [7:0]  green;
		logic [7:0]  red;
		logic [11:0] pos_y;
		logic [11:0] pos_x;
	} splat_item_t;

	class splat_scoreboard;
		wss_pkg::pixel_t frame [NUM_PIXELS];
		wss_pkg::pixel_t expected_px [$];
		int errors;
		int n_splat;
		int n_read;
		int n_dropped;
		int n_saturated;

		function new();
			foreach (frame[i]) frame[i] = '0;
			errors = 0;
			n_splat = 0;
			n_read = 0;
			n_dropped = 0;
			n_saturated = 0;
		endfunction

		function int unsigned corner_weight(int unsigned a, int unsigned b);
			return (a * b + a + b) >> 8;
		endfunction

		function logic [7:0] sat_add(logic [7:0] s, int unsigned add);
			int unsigned t;
			t = 32'(s) + add;
			if (t > 255) begin
				n_saturated++;
				return 8'hFF;
			end
			return t[7:0];
		endfunction

		function void note_item(logic kind, splat_item_t it);
			int unsigned fx, fy, a, b, w, col, row, p;
			if (kind == wss_pkg::KIND_READ) begin
				n_read++;
				if (it.pixel_index < NUM_PIXELS)
					expected_px.push_back(frame[it.pixel_index]);
				else
					expected_px.push_back('0);
			end else begin
				n_splat++;
				fx = 32'(it.pos_x[7:0]);
				fy = 32'(it.pos_y[7:0]);
				for (int k = 0; k < 4; k++) begin
					a = (k & 1) ? fx : 255 - fx;
					b = (k & 2) ? fy : 255 - fy;
					w = corner_weight(a, b);
					col = 32'(it.pos_x[11:8]) + 32'(k & 1);
					row = 32'(it.pos_y[11:8]) + 32'((k >> 1) & 1);
					if (col >= GRID_COLS || row >= GRID_ROWS) begin
						n_dropped++;
					end else begin
						p = row * GRID_COLS + col;
						frame[p].red   = sat_add(frame[p].red,   (it.red   * w) >> 8);
						frame[p].green = sat_add(frame[p].green, (it.green * w) >> 8);
						frame[p].blue  = sat_add(frame[p].blue,  (it.blue  * w) >> 8);
					end
				end
				expected_px.push_back('0);
			end
		endfunction

		function void check_pixel(wss_pkg::pixel_t got);
			wss_pkg::pixel_t want;
			if (expected_px.size() == 0) begin
				$error("result with nothing pending: %h", got);
				errors++;
			end else begin
				want = expected_px.pop_front();
				if (got.red !== want.red) begin
					$error("pixel_red: expected %0d, got %0d", want.red, got.red);
					errors++;
				end
				if (got.green !== want.green) begin
					$error("pixel_green: expected %0d, got %0d", want.green, got.green);
					errors++;
				end
				if (got.blue !== want.blue) begin
					$error("pixel_blue: expected %0d, got %0d", want.blue, got.blue);
					errors++;
				end
			end
		endfunction

		function int outstanding();
			return expected_px.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	splat_scoreboard sb;
	int idle_pct;
	int stall_pct;
	int hold_len;
	int last_cell;

	wu_subpixel_splat #(
		.GRID_COLS(GRID_COLS),
		.GRID_ROWS(GRID_ROWS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("[wu_subpixel_splat] ERROR");
		$finish;
	end

	// sample both sides at the edge; check before noting the new input
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				sb.check_pixel(m_tdata);
			if (s_tvalid && s_tready)
				sb.note_item(s_tuser, s_tdata);
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				m_tready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	function automatic splat_item_t pack_item(int x, int y, int r, int g, int b, int idx);
		splat_item_t it;
		it.pos_x = 12'(x);
		it.pos_y = 12'(y);
		it.red = 8'(r);
		it.green = 8'(g);
		it.blue = 8'(b);
		it.pixel_index = 8'(idx);
		return it;
	endfunction

	task automatic send_item(logic kind, splat_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= it;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_random();
		splat_item_t it;
		logic kind;
		logic [63:0] rnd;
		rnd = {$urandom, $urandom};
		it = rnd[55:0];
		kind = ($urandom_range(99) < 55) ? wss_pkg::KIND_SPLAT : wss_pkg::KIND_READ;
		if (kind == wss_pkg::KIND_SPLAT) begin
			// mostly dim colors so the frame does not saturate early
			if ($urandom_range(3) != 0) begin
				it.red = 8'($urandom_range(48));
				it.green = 8'($urandom_range(48));
				it.blue = 8'($urandom_range(48));
			end
			last_cell = int'(it.pos_y[11:8]) * GRID_COLS + int'(it.pos_x[11:8]);
		end else if ($urandom_range(1) == 0) begin
			// read back around the last splat
			it.pixel_index = 8'(last_cell + int'($urandom_range(1)) +
				GRID_COLS * int'($urandom_range(1)));
		end
		send_item(kind, it);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0) @(posedge clk);
	endtask

	initial begin
		sb = new();
		idle_pct = 0;
		stall_pct = 0;
		hold_len = 0;
		last_cell = 0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser <= wss_pkg::KIND_SPLAT;
		s_tdata <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: cleared store, extremes, edge drops, saturation, ignored fields
		send_item(wss_pkg::KIND_READ,  pack_item(12'hFFF, 12'hFFF, 255, 255, 255, 0));
		send_item(wss_pkg::KIND_READ,  pack_item(12'h000, 12'h000, 0, 0, 0, 255));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'h000, 12'h000, 255, 255, 255, 255));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 0));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'h080, 12'h080, 255, 0, 128, 17));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 1));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 16));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 17));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'hFFF, 12'hFFF, 255, 255, 255, 0));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'hF00, 12'hF00, 255, 255, 255, 0));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 255));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'hF40, 12'h340, 200, 100, 50, 0));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 3 * GRID_COLS + 15));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'h380, 12'hFC0, 50, 100, 200, 0));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 15 * GRID_COLS + 3));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 15 * GRID_COLS + 4));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'h000, 12'h000, 255, 255, 255, 0));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'h000, 12'h000, 255, 255, 255, 0));
		send_item(wss_pkg::KIND_READ,  pack_item(12'hABC, 12'h123, 77, 88, 99, 0));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'h5A5, 12'hA5A, 0, 0, 0, 0));
		send_item(wss_pkg::KIND_SPLAT, pack_item(12'h7FF, 12'h800, 1, 2, 3, 0));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 8 * GRID_COLS + 7));
		send_item(wss_pkg::KIND_READ,  pack_item(0, 0, 0, 0, 0, 8 * GRID_COLS + 8));
		drain();

		// random phases with different idle and stall mixes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 72; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 72; end
				default: begin idle_pct = 15; stall_pct = 15; end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_random();

			// back up the block once: hold the receiver, keep offering items
			if (ph == 1) begin
				idle_pct = 0;
				hold_len = HOLD_CYCLES;
				for (int i = 0; i < 30; i++)
					send_random();
			end
			drain();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.outstanding() != 0) begin
			$error("%0d results never arrived", sb.outstanding());
			sb.errors++;
		end
		$display("covered %0d splats and %0d reads", sb.n_splat, sb.n_read);
		$display("off-grid neighbors dropped: %0d, saturated channel adds: %0d",
			sb.n_dropped, sb.n_saturated);
		if (sb.errors == 0)
			$display("[wu_subpixel_splat] OK");
		else
			$display("[wu_subpixel_splat] ERROR");
		$finish;
	end

endmodule

>>> wu_subpixel_splat.f
src/wss_pkg.sv
src/wss_mac.sv
src/wss_frame_mem.sv
src/wu_subpixel_splat.sv
tb/tb_wu_subpixel_splat.sv
